[rtl/sacr_pkg.sv]
// Shared constants, defaults and helper functions of the random-replacement cache tag store.
`default_nettype none

package sacr_pkg;

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 4;

  localparam logic [CfgIdxW-1:0] CFG_OFFSET_WIDTH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SET_WIDTH    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WAYS_IN_USE  = 2'd2;

  localparam logic [CfgDataW-1:0] OFFSET_WIDTH_RST = 4'd4;
  localparam logic [CfgDataW-1:0] SET_WIDTH_RST    = 4'd6;
  localparam logic [CfgDataW-1:0] WAYS_IN_USE_RST  = 4'd4;
  localparam logic [CfgDataW-1:0] OFFSET_WIDTH_MAX = 4'd12;

  // Payload widths fixed by the channel definitions
  localparam int AddrW     = 32;
  localparam int SetIndexW = 8;
  localparam int WayOutW   = 3;
  localparam int CountW    = 32;

  // Parameter defaults
  localparam int ADDR_BITS_DEF = 32;
  localparam int MAX_SETS_DEF  = 256;
  localparam int MAX_WAYS_DEF  = 8;

  localparam int                 LfsrW    = 16;
  localparam logic [LfsrW-1:0]   LFSR_RST = 16'hACE1;
  localparam logic [CountW-1:0]  COUNT_MAX = '1;

  // Widest set index usable: at most 8 bits and no more sets than exist
  function automatic int set_lim_w(input int max_sets);
    int s;
    s = 0;
    while (s < 8 && (2 << s) <= max_sets) s++;
    return s;
  endfunction

  // x^16+x^14+x^13+x^11+1, shift right, feedback into the top bit
  function automatic logic [LfsrW-1:0] lfsr_next(input logic [LfsrW-1:0] v);
    logic b;
    b = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {b, v[LfsrW-1:1]};
  endfunction

  // Eight restoring remainder steps: shift in bits MSB first, subtract k when it fits
  function automatic logic [3:0] mod_steps(input logic [3:0] r_in,
                                           input logic [7:0] bits,
                                           input logic [3:0] k);
    logic [4:0] r;
    r = {1'b0, r_in};
    for (int i = 7; i >= 0; i--) begin
      r = {r[3:0], bits[i]};
      if (r >= {1'b0, k}) begin
        r = r - {1'b0, k};
      end
    end
    return r[3:0];
  endfunction

endpackage

`default_nettype wire

[rtl/sacr_if.sv]
// Handshake channels for the cache tag store: address request and lookup response.
`default_nettype none

interface sacr_req_if;
  logic                         valid;
  logic                         ready;
  logic [sacr_pkg::AddrW-1:0]   address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface sacr_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic [sacr_pkg::SetIndexW-1:0]   set_index;
  logic [sacr_pkg::WayOutW-1:0]     way;
  logic [sacr_pkg::CountW-1:0]      hit_count;
  logic [sacr_pkg::CountW-1:0]      miss_count;

  modport source (output valid, output hit, output set_index, output way,
                  output hit_count, output miss_count, input ready);
  modport sink   (input valid, input hit, input set_index, input way,
                  input hit_count, input miss_count, output ready);
endinterface

`default_nettype wire

[rtl/set_assoc_cache_random_replace_top.sv]
// Top level of the set-associative cache tag store with random (LFSR) replacement.
//
// Usage: each transfer on req_i carries one byte address. The block drops the
// offset bits, picks a set, and compares the tag against every valid way in use.
// One response per request leaves on rsp_o: hit flag, set, way hit or filled,
// and the saturating hit and miss totals including this access.
// Configuration (offset width, set width, ways in use) is written through
// cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must write it only while no
// request is in flight, as the block itself does not enforce this.
// Flow: a taken request has the tag and valid rows of its set read from the
// memories; the lookup state then compares, writes back on a miss and loads
// the response register once the response slot is free. No new request is
// taken until the lookup has finished. The response is registered: valid rises
// when the lookup loads the response register.
// Reset: the LFSR, totals and configuration go to their reset values, then a
// clearing pass zeroes the valid memory, one set row a cycle, over all
// 2^min(8, log2 MAX_SETS) set rows; no request is taken meanwhile.
// Stall: a stalled response is held in the output register; one more request
// is still taken and waits in the lookup state until the response slot frees.
`default_nettype none

module set_assoc_cache_random_replace_top #(
  parameter int ADDR_BITS = sacr_pkg::ADDR_BITS_DEF,
  parameter int MAX_SETS  = sacr_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS  = sacr_pkg::MAX_WAYS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [sacr_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire [sacr_pkg::CfgDataW-1:0]     cfg_wdata_i,
  sacr_req_if.sink                         req_i,
  sacr_rsp_if.source                       rsp_o
);

  localparam int SetLimW = sacr_pkg::set_lim_w(MAX_SETS);
  localparam int Rows    = 1 << SetLimW;
  localparam int IdxW    = (SetLimW == 0) ? 1 : SetLimW;
  localparam int WayW    = (MAX_WAYS <= 1) ? 1 : $clog2(MAX_WAYS);
  localparam int TagW    = ADDR_BITS;
  localparam int ShW     = 5;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [3:0] off_q, sw_q, ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q  <= sacr_pkg::OFFSET_WIDTH_RST;
      sw_q   <= sacr_pkg::SET_WIDTH_RST;
      ways_q <= sacr_pkg::WAYS_IN_USE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sacr_pkg::CFG_OFFSET_WIDTH: off_q  <= cfg_wdata_i;
        sacr_pkg::CFG_SET_WIDTH:    sw_q   <= cfg_wdata_i;
        sacr_pkg::CFG_WAYS_IN_USE:  ways_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp register values to the legal ranges
  logic [3:0] off_c, sw_c, ways_c;

  always_comb begin
    off_c = (off_q > sacr_pkg::OFFSET_WIDTH_MAX) ? sacr_pkg::OFFSET_WIDTH_MAX : off_q;
    sw_c  = (sw_q > 4'(SetLimW)) ? 4'(SetLimW) : sw_q;
    if (ways_q == 4'd0) begin
      ways_c = 4'd1;
    end else if ({1'b0, ways_q} > 5'(MAX_WAYS)) begin
      ways_c = 4'(MAX_WAYS);
    end else begin
      ways_c = ways_q;
    end
  end

  // Address decode for the incoming transfer
  logic [ADDR_BITS-1:0]          addr_c;
  logic [sacr_pkg::SetIndexW-1:0] set_mask_c, set_c;
  logic [TagW-1:0]               tag_c;
  logic [ShW-1:0]                tag_sh_c;

  always_comb begin
    addr_c     = req_i.address[ADDR_BITS-1:0];
    set_mask_c = 8'((9'd1 << sw_c) - 9'd1);
    set_c      = 8'(addr_c >> off_c) & set_mask_c;
    tag_sh_c   = ShW'(off_c) + ShW'(sw_c);
    tag_c      = addr_c >> tag_sh_c;
  end

  logic req_fire;
  logic req_ready_c;
  assign req_ready_c = (state_q == S_IDLE);
  assign req_i.ready = req_ready_c;
  assign req_fire    = req_i.valid && req_ready_c;

  // Victim selection: next LFSR value modulo the ways, split over the request and lookup states
  logic [sacr_pkg::LfsrW-1:0] lfsr_q, lfsr_nx;
  logic [3:0]                 rem_hi_c, rem_hi_q, vic_rem;

  assign lfsr_nx  = sacr_pkg::lfsr_next(lfsr_q);
  assign rem_hi_c = sacr_pkg::mod_steps(4'd0, lfsr_nx[15:8], ways_c);

  // Lookup stage holding registers
  logic [sacr_pkg::SetIndexW-1:0] set_lk_q;
  logic [TagW-1:0]                tag_lk_q;
  logic [3:0]                     ways_lk_q;
  logic [IdxW-1:0]                clr_idx_q;

  // Memories: tag rows with per-way write, valid rows written whole
  logic [TagW-1:0]     tag_mem [Rows][MAX_WAYS];
  logic [TagW-1:0]     tag_rd_q [MAX_WAYS];
  logic [MAX_WAYS-1:0] vld_mem [Rows];
  logic [MAX_WAYS-1:0] vld_rd_q;

  logic [IdxW-1:0] rd_idx;
  assign rd_idx = set_c[IdxW-1:0];

  // Compare across the ways, lowest match wins
  logic [MAX_WAYS-1:0] match;
  logic                hit_c;
  logic [WayW-1:0]     hit_way, fill_way, way_c;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      match[w] = vld_rd_q[w] && (tag_rd_q[w] == tag_lk_q) && (5'(w) < {1'b0, ways_lk_q});
    end
    hit_c   = |match;
    hit_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WayW'(w);
      end
    end
  end

  assign vic_rem  = sacr_pkg::mod_steps(rem_hi_q, lfsr_nx[7:0], ways_lk_q);
  assign fill_way = (ways_lk_q > 4'd1) ? WayW'(vic_rem) : '0;
  assign way_c    = hit_c ? hit_way : fill_way;

  // Finish the lookup once the response slot is free
  logic rsp_vld_q;
  logic done;
  logic miss_wr;

  assign done    = (state_q == S_LOOKUP) && (!rsp_vld_q || rsp_o.ready);
  assign miss_wr = done && !hit_c;

  // Valid memory write port: clearing pass or fill on a miss
  logic                vld_we;
  logic [IdxW-1:0]     vld_wa;
  logic [MAX_WAYS-1:0] vld_wd;

  always_comb begin
    vld_we = (state_q == S_CLEAR) || miss_wr;
    vld_wa = (state_q == S_CLEAR) ? clr_idx_q : set_lk_q[IdxW-1:0];
    for (int w = 0; w < MAX_WAYS; w++) begin
      vld_wd[w] = (state_q != S_CLEAR) && (vld_rd_q[w] || (fill_way == WayW'(w)));
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      tag_rd_q <= tag_mem[rd_idx];
      vld_rd_q <= vld_mem[rd_idx];
    end
    if (miss_wr) begin
      tag_mem[set_lk_q[IdxW-1:0]][fill_way] <= tag_lk_q;
    end
    if (vld_we) begin
      vld_mem[vld_wa] <= vld_wd;
    end
  end

  // Saturating totals including the access being finished
  logic [sacr_pkg::CountW-1:0] hit_tot_q, miss_tot_q, hit_tot_d, miss_tot_d;

  always_comb begin
    hit_tot_d  = hit_tot_q;
    miss_tot_d = miss_tot_q;
    if (hit_c) begin
      if (hit_tot_q != sacr_pkg::COUNT_MAX) hit_tot_d = hit_tot_q + 1'b1;
    end else begin
      if (miss_tot_q != sacr_pkg::COUNT_MAX) miss_tot_d = miss_tot_q + 1'b1;
    end
  end

  // Response register
  logic                           rsp_hit_q;
  logic [sacr_pkg::SetIndexW-1:0] rsp_set_q;
  logic [sacr_pkg::WayOutW-1:0]   rsp_way_q;
  logic [sacr_pkg::CountW-1:0]    rsp_hcnt_q, rsp_mcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_idx_q  <= '0;
      lfsr_q     <= sacr_pkg::LFSR_RST;
      hit_tot_q  <= '0;
      miss_tot_q <= '0;
      rsp_vld_q  <= 1'b0;
      rsp_hit_q  <= 1'b0;
      rsp_set_q  <= '0;
      rsp_way_q  <= '0;
      rsp_hcnt_q <= '0;
      rsp_mcnt_q <= '0;
      set_lk_q   <= '0;
      tag_lk_q   <= '0;
      ways_lk_q  <= 4'd1;
      rem_hi_q   <= '0;
    end else begin
      // load a finished lookup, else drop the response once the sink takes it
      if (done) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_idx_q <= clr_idx_q + 1'b1;
          if (clr_idx_q == IdxW'(Rows - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            set_lk_q  <= set_c;
            tag_lk_q  <= tag_c;
            ways_lk_q <= ways_c;
            rem_hi_q  <= rem_hi_c;
            state_q   <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (done) begin
            hit_tot_q  <= hit_tot_d;
            miss_tot_q <= miss_tot_d;
            if (!hit_c && ways_lk_q > 4'd1) begin
              lfsr_q <= lfsr_nx;
            end
            rsp_hit_q  <= hit_c;
            rsp_set_q  <= set_lk_q;
            rsp_way_q  <= sacr_pkg::WayOutW'(way_c);
            rsp_hcnt_q <= hit_tot_d;
            rsp_mcnt_q <= miss_tot_d;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid      = rsp_vld_q;
  assign rsp_o.hit        = rsp_hit_q;
  assign rsp_o.set_index  = rsp_set_q;
  assign rsp_o.way        = rsp_way_q;
  assign rsp_o.hit_count  = rsp_hcnt_q;
  assign rsp_o.miss_count = rsp_mcnt_q;

endmodule

`default_nettype wire
